FILE: hdl/esc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants for the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

  // constant divisions by reciprocal: q = (x * Recip) >> FracBits, with Recip
  // rounded up; exact over the whole range of x that reaches each stage
  // days: (secs >> 7) / 675, as 86400 = 675 << 7
  localparam int unsigned DayFracBits  = 35;
  localparam logic [9:0]  DayOdd       = 10'd675;
  localparam logic [25:0] DayRecip     =
    26'(((64'd1 << DayFracBits) + 64'(DayOdd) - 64'd1) / 64'(DayOdd));
  // hours: (tod >> 4) / 225, as 3600 = 225 << 4
  localparam int unsigned HourFracBits = 21;
  localparam logic [7:0]  HourOdd      = 8'd225;
  localparam logic [13:0] HourRecip    =
    14'(((64'd1 << HourFracBits) + 64'(HourOdd) - 64'd1) / 64'(HourOdd));
  // minutes: (rem >> 2) / 15, as 60 = 15 << 2
  localparam int unsigned MinFracBits  = 14;
  localparam logic [3:0]  MinOdd       = 4'd15;
  localparam logic [10:0] MinRecip     =
    11'(((64'd1 << MinFracBits) + 64'(MinOdd) - 64'd1) / 64'(MinOdd));

  localparam logic [11:0] BaseYear    = 12'd1970;
  localparam logic [1:0]  BaseMod4    = 2'd2;
  localparam logic [6:0]  BaseMod100  = 7'd70;
  localparam logic [8:0]  BaseMod400  = 9'd370;
  localparam logic [8:0]  DaysLeap    = 9'd366;
  localparam logic [8:0]  DaysCommon  = 9'd365;
  localparam logic [3:0]  LastMonth   = 4'd11;

  // day count and time of day handed from the front to the back
  typedef struct packed {
    logic [15:0] days;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } item_t;

  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
      4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
      4'd1:                                      len = leap ? 5'd29 : 5'd28;
      default:                                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

FILE: hdl/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// Flow: the front splits an accepted item into whole days and time of day, the
//   queue holds it, and the back walks Y = year - 1970 (0..136) years, then months.
// Throughput: the front takes a new item only once it has pushed the last one
//   into the queue; the back works on one item at a time and holds it until popped.
// Reset: asynchronous, active low; clears all control state, queue empties.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts unsigned seconds since 1970-01-01 00:00:00 to a calendar date and
// time of day, with queue-style handshakes on both sides.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] epoch_seconds_i,
  output logic        empty,
  input  logic        pop,
  output logic [11:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o
);
  import esc_pkg::*;

  logic  wr;
  item_t wr_item;
  logic  q_full;
  logic  q_rd;
  item_t rd_item;
  logic  q_empty;

  esc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .epoch_seconds_i(epoch_seconds_i),
    .wr_o           (wr),
    .wr_item_o      (wr_item),
    .q_full_i       (q_full)
  );

  esc_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .wr_item_i(wr_item),
    .full_o   (q_full),
    .rd_i     (q_rd),
    .rd_item_o(rd_item),
    .empty_o  (q_empty)
  );

  esc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_empty_i(q_empty),
    .q_item_i (rd_item),
    .q_rd_o   (q_rd),
    .empty    (empty),
    .pop      (pop),
    .year_o   (year_o),
    .month_o  (month_o),
    .day_o    (day_o),
    .hour_o   (hour_o),
    .minute_o (minute_o),
    .second_o (second_o)
  );

endmodule

FILE: hdl/esc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_front
// Accepts an item and splits it into whole days, hour, minute and second
// by reciprocal multiplication, one multiply a cycle.
// ----------------------------------------------------------------------------
module esc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  logic [31:0]   epoch_seconds_i,
  output logic          wr_o,
  output esc_pkg::item_t wr_item_o,
  input  logic          q_full_i
);
  import esc_pkg::*;

  typedef enum logic [2:0] {
    F_IDLE,
    F_DAYS,
    F_DREM,
    F_HOUR,
    F_HREM,
    F_MIN,
    F_SEC,
    F_PUSH
  } state_e;

  state_e      state_q;
  logic [31:0] secs_q;
  logic [16:0] tod_q;
  logic [11:0] hrem_q;
  item_t       item_q;

  logic [50:0] day_prod;
  logic [25:0] day_back;
  logic [25:0] day_rem;
  logic [26:0] hour_prod;
  logic [12:0] hour_back;
  logic [12:0] hour_rem;
  logic [20:0] min_prod;
  logic [9:0]  min_back;
  logic [9:0]  min_rem;

  // low bits below each odd divisor pass straight into the remainder
  always_comb begin
    day_prod  = 51'(secs_q[31:7]) * 51'(DayRecip);
    day_back  = 26'(item_q.days) * 26'(DayOdd);
    day_rem   = 26'(secs_q[31:7]) - day_back;
    hour_prod = 27'(tod_q[16:4]) * 27'(HourRecip);
    hour_back = 13'(item_q.hour) * 13'(HourOdd);
    hour_rem  = tod_q[16:4] - hour_back;
    min_prod  = 21'(hrem_q[11:2]) * 21'(MinRecip);
    min_back  = 10'(item_q.minute) * 10'(MinOdd);
    min_rem   = hrem_q[11:2] - min_back;
  end

  assign full      = state_q != F_IDLE;
  assign wr_o      = (state_q == F_PUSH) && !q_full_i;
  assign wr_item_o = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      case (state_q)
        F_IDLE: begin
          if (push) begin
            secs_q  <= epoch_seconds_i;
            state_q <= F_DAYS;
          end
        end
        F_DAYS: begin
          item_q.days <= day_prod[DayFracBits +: 16];
          state_q     <= F_DREM;
        end
        F_DREM: begin
          tod_q   <= {day_rem[9:0], secs_q[6:0]};
          state_q <= F_HOUR;
        end
        F_HOUR: begin
          item_q.hour <= hour_prod[HourFracBits +: 5];
          state_q     <= F_HREM;
        end
        F_HREM: begin
          hrem_q  <= {hour_rem[7:0], tod_q[3:0]};
          state_q <= F_MIN;
        end
        F_MIN: begin
          item_q.minute <= min_prod[MinFracBits +: 6];
          state_q       <= F_SEC;
        end
        F_SEC: begin
          item_q.second <= {min_rem[3:0], hrem_q[1:0]};
          state_q       <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hdl/esc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_fifo
// Two-entry queue decoupling the divider front from the calendar back.
// ----------------------------------------------------------------------------
module esc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  esc_pkg::item_t wr_item_i,
  output logic           full_o,
  input  logic           rd_i,
  output esc_pkg::item_t rd_item_o,
  output logic           empty_o
);
  import esc_pkg::*;

  item_t      mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] cnt_q;

  logic do_wr;
  logic do_rd;

  assign full_o    = cnt_q == 2'd2;
  assign empty_o   = cnt_q == 2'd0;
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (do_rd) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/esc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_back
// Walks the day count year by year from 1970, then month by month, and
// holds the finished date in the output register until it is taken.
// ----------------------------------------------------------------------------
module esc_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  esc_pkg::item_t q_item_i,
  output logic           q_rd_o,
  output logic           empty,
  input  logic           pop,
  output logic [11:0]    year_o,
  output logic [3:0]     month_o,
  output logic [4:0]     day_o,
  output logic [4:0]     hour_o,
  output logic [5:0]     minute_o,
  output logic [5:0]     second_o
);
  import esc_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE,
    B_YEAR,
    B_MONTH,
    B_HOLD
  } state_e;

  state_e      state_q;
  logic [15:0] days_q;
  logic [11:0] year_q;
  logic [3:0]  mon_q;
  logic [1:0]  mod4_q;
  logic [6:0]  mod100_q;
  logic [8:0]  mod400_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;

  logic        leap;
  logic [15:0] ylen;
  logic [15:0] mlen;

  // leap rule tracked by running residues rather than division
  always_comb begin
    leap = ((mod4_q == 2'd0) && (mod100_q != 7'd0)) || (mod400_q == 9'd0);
    ylen = {7'd0, leap ? DaysLeap : DaysCommon};
    mlen = {11'd0, month_len(leap, mon_q)};
  end

  assign q_rd_o   = (state_q == B_IDLE) && !q_empty_i;
  assign empty    = state_q != B_HOLD;
  assign year_o   = year_q;
  assign month_o  = mon_q + 4'd1;
  assign day_o    = days_q[4:0] + 5'd1;
  assign hour_o   = hour_q;
  assign minute_o = minute_q;
  assign second_o = second_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!q_empty_i) begin
            days_q   <= q_item_i.days;
            hour_q   <= q_item_i.hour;
            minute_q <= q_item_i.minute;
            second_q <= q_item_i.second;
            year_q   <= BaseYear;
            mod4_q   <= BaseMod4;
            mod100_q <= BaseMod100;
            mod400_q <= BaseMod400;
            mon_q    <= '0;
            state_q  <= B_YEAR;
          end
        end
        B_YEAR: begin
          if (days_q < ylen) begin
            state_q <= B_MONTH;
          end else begin
            days_q   <= days_q - ylen;
            year_q   <= year_q + 12'd1;
            mod4_q   <= mod4_q + 2'd1;
            mod100_q <= (mod100_q == 7'd99) ? 7'd0 : mod100_q + 7'd1;
            mod400_q <= (mod400_q == 9'd399) ? 9'd0 : mod400_q + 9'd1;
          end
        end
        B_MONTH: begin
          if ((mon_q < LastMonth) && (days_q >= mlen)) begin
            days_q <= days_q - mlen;
            mon_q  <= mon_q + 4'd1;
          end else begin
            state_q <= B_HOLD;
          end
        end
        B_HOLD: begin
          if (pop) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: dv/epoch_seconds_to_calendar_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_checker
// Watches both queue sides of the converter. Every accepted item is turned
// into an expected calendar date and time of day. Each popped result is
// compared field by field with the oldest expected date. Mismatches and
// unexpected results are counted.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [31:0] epoch_seconds_i,
  input  logic        empty_i,
  input  logic        pop_i,
  input  logic [11:0] year_i,
  input  logic [3:0]  month_i,
  input  logic [4:0]  day_i,
  input  logic [4:0]  hour_i,
  input  logic [5:0]  minute_i,
  input  logic [5:0]  second_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  localparam int unsigned DaySecs  = 86400;
  localparam int unsigned HourSecs = 3600;
  localparam int unsigned MinSecs  = 60;
  localparam int unsigned EpochYear = 1970;
  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } calendar_t;

  calendar_t dates_q[$];

  function automatic bit is_leap_year(input int unsigned yr);
    return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
  endfunction

  function automatic calendar_t calendar_of(input logic [31:0] secs);
    int unsigned tod;
    int unsigned days;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    calendar_t   c;
    tod  = secs % DaySecs;
    days = secs / DaySecs;
    yr   = EpochYear;
    while (days >= (is_leap_year(yr) ? 366 : 365)) begin
      days -= is_leap_year(yr) ? 366 : 365;
      yr++;
    end
    mon = 0;
    // December takes whatever is left
    while (mon < 11) begin
      mlen = MonthDays[mon] + ((mon == 1 && is_leap_year(yr)) ? 1 : 0);
      if (days < mlen) break;
      days -= mlen;
      mon++;
    end
    c.year   = 12'(yr);
    c.month  = 4'(mon + 1);
    c.day    = 5'(days + 1);
    c.hour   = 5'(tod / HourSecs);
    c.minute = 6'((tod % HourSecs) / MinSecs);
    c.second = 6'(tod % MinSecs);
    return c;
  endfunction

  task automatic compare_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
      errors_o++;
    end
  endtask

  always @(posedge clk_i) begin
    calendar_t want;
    if (rst_ni) begin
      if (push_i && !full_i) dates_q.insert(dates_q.size(), calendar_of(epoch_seconds_i));
      if (pop_i && !empty_i) begin
        if (dates_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %0d-%0d-%0d %0d:%0d:%0d",
                   $time, year_i, month_i, day_i, hour_i, minute_i, second_i);
          errors_o++;
        end else begin
          want = dates_q.pop_front();
          compare_field("year",   want.year,   year_i);
          compare_field("month",  want.month,  month_i);
          compare_field("day",    want.day,    day_i);
          compare_field("hour",   want.hour,   hour_i);
          compare_field("minute", want.minute, minute_i);
          compare_field("second", want.second, second_i);
        end
      end
      pending_o = dates_q.size();
    end
  end

endmodule

FILE: dv/tb_epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Drives second counts into the converter: boundary dates first, then random
// counts biased towards midnight and year edges, with bursty push and pop
// idling that stops near the end. Checking is done by the checker module.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_top;

  localparam int unsigned RandomItems = 1200;
  localparam int unsigned QuietItems  = 150;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned DrainCycles = 250;
  localparam longint unsigned MaxSecs = 64'hFFFF_FFFF;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [31:0] epoch_seconds_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [11:0] year_o;
  logic [3:0]  month_o;
  logic [4:0]  day_o;
  logic [4:0]  hour_o;
  logic [5:0]  minute_o;
  logic [5:0]  second_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned idle_cycles = 0;
  bit          quiet = 1'b0;

  always #2 clk_i = ~clk_i;

  epoch_seconds_to_calendar_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .epoch_seconds_i(epoch_seconds_i),
    .empty          (empty),
    .pop            (pop),
    .year_o         (year_o),
    .month_o        (month_o),
    .day_o          (day_o),
    .hour_o         (hour_o),
    .minute_o       (minute_o),
    .second_o       (second_o)
  );

  epoch_seconds_to_calendar_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_i         (full),
    .epoch_seconds_i(epoch_seconds_i),
    .empty_i        (empty),
    .pop_i          (pop),
    .year_i         (year_o),
    .month_i        (month_o),
    .day_i          (day_o),
    .hour_i         (hour_o),
    .minute_i       (minute_o),
    .second_i       (second_o),
    .errors_o       (errors),
    .pending_o      (pending)
  );

  // hangs show up as a long run of cycles without any handshake
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("tb_epoch_seconds_to_calendar_top failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall bursts until the quiet tail
  initial begin
    int unsigned burst;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 17);
        pop <= 1'b0;
        repeat (burst - 1) @(negedge clk_i);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic send_seconds(input logic [31:0] secs);
    int unsigned burst;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      burst = $urandom_range(1, 17);
      push <= 1'b0;
      repeat (burst) @(negedge clk_i);
    end
    push <= 1'b1;
    epoch_seconds_i <= secs;
    do @(posedge clk_i); while (full);
  endtask

  // mostly day-aligned, early or late counts, so month and year edges get hit
  function automatic logic [31:0] random_seconds();
    longint unsigned s;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: s = $urandom();
      4, 5, 6: begin
        s = longint'($urandom_range(0, 49710)) * 86400;
        if ($urandom_range(0, 1) == 1) s += 86399;
        if (s > MaxSecs) s = MaxSecs;
      end
      7, 8:    s = $urandom_range(0, 157766399);
      default: s = MaxSecs - $urandom_range(0, 40000000);
    endcase
    return s[31:0];
  endfunction

  initial begin
    logic [31:0] directed [$];
    directed = '{
      32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
      32'd31535999, 32'd31536000,         // first new year
      32'd68169600, 32'd94694399,         // leap day and last day of a leap year
      32'd951782399, 32'd951782400,       // 2000 keeps its leap day
      32'd951868800,
      32'd4107456000, 32'd4107542400,     // 2100 does not
      32'h7FFF_FFFF, 32'h8000_0000,
      32'hAAAA_AAAA, 32'h5555_5555,
      32'd4291747200,
      32'hFFFF_FFFE, 32'hFFFF_FFFF
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[i]) send_seconds(directed[i]);
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == RandomItems - QuietItems) quiet = 1'b1;
      send_seconds(random_seconds());
    end
    @(negedge clk_i);
    push <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    if (errors == 0) begin
      $display("tb_epoch_seconds_to_calendar_top passed");
    end else begin
      $display("tb_epoch_seconds_to_calendar_top failed");
    end
    $finish;
  end

endmodule
